// ===== sv/foot_target_euler_rotate_unit_assert.svh =====
// Assertion macros for the foot target rotation unit.
`ifndef FOOT_TARGET_EULER_ROTATE_UNIT_ASSERT_SVH
`define FOOT_TARGET_EULER_ROTATE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FTER_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define FTER_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/fter_pkg.sv =====
// Shared constants, types and functions of the foot target rotation unit.
package fter_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AngW = 20;   // Q.16 angle, +-8*2^16 plus margin
  localparam int unsigned TrigW = 18;  // Q.16 sine/cosine, |v| <= ~1.0
  localparam int unsigned PosW = 18;   // pipeline position width
  localparam int unsigned OutW = 18;
  localparam logic signed [AngW-1:0] AngPi = AngW'(205887);
  localparam logic signed [AngW-1:0] AngHalfPi = AngW'(102944);
  localparam logic signed [TrigW-1:0] CordicGain = TrigW'(39797);

  typedef struct packed {
    logic signed [TrigW-1:0] c;
    logic signed [TrigW-1:0] s;
  } trig_t;

  typedef struct packed {
    trig_t roll;
    trig_t pitch;
    trig_t yaw;
  } trig3_t;

  typedef struct packed {
    logic signed [15:0] foot_x;
    logic signed [15:0] foot_y;
    logic signed [15:0] foot_z;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic signed [15:0] mount_cosine;
    logic signed [15:0] mount_sine;
    logic [14:0] body_height;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } req_t;

  // Side data carried alongside the CORDIC pipeline.
  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic signed [15:0] mount_cosine;
    logic signed [15:0] mount_sine;
  } pt_t;

  function automatic logic signed [AngW-1:0] atan_q16(input int unsigned i);
    logic signed [AngW-1:0] r;
    case (i)
      0: r = AngW'(51472);
      1: r = AngW'(30386);
      2: r = AngW'(16055);
      3: r = AngW'(8150);
      4: r = AngW'(4091);
      5: r = AngW'(2047);
      6: r = AngW'(1024);
      7: r = AngW'(512);
      8: r = AngW'(256);
      9: r = AngW'(128);
      10: r = AngW'(64);
      11: r = AngW'(32);
      12: r = AngW'(16);
      13: r = AngW'(8);
      14: r = AngW'(4);
      15: r = AngW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Saturate to 18-bit signed range.
  function automatic logic signed [OutW-1:0] sat18(input logic signed [47:0] v);
    logic signed [OutW-1:0] r;
    if (v > 48'sd131071) r = 18'sd131071;
    else if (v < -48'sd131072) r = -18'sd131072;
    else r = v[OutW-1:0];
    return r;
  endfunction

endpackage

// ===== sv/fter_cordic.sv =====
// Pipelined sine/cosine CORDIC for three angles with side payload.
module fter_cordic import fter_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic signed [15:0]  roll_i,
  input  logic signed [15:0]  pitch_i,
  input  logic signed [15:0]  yaw_i,
  input  pt_t                 pt_i,
  output logic                vld_o,
  output trig3_t              trig_o,
  output pt_t                 pt_o
);

  localparam int unsigned NS = CordicSteps + 1;

  logic                    vld_q [NS];
  pt_t                     pt_q  [NS];
  logic signed [TrigW-1:0] x_q [3][NS];
  logic signed [TrigW-1:0] y_q [3][NS];
  logic signed [AngW-1:0]  a_q [3][NS];
  logic                    flip_q [3][NS];

  logic signed [15:0]      ang_in [3];
  logic signed [AngW-1:0]  a_red [3];
  logic                    f_red [3];

  assign ang_in[0] = roll_i;
  assign ang_in[1] = pitch_i;
  assign ang_in[2] = yaw_i;

  // Range reduction: at most four pi steps.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_red[k] = AngW'({ang_in[k], 4'b0000});
      f_red[k] = 1'b0;
      for (int r = 0; r < 4; r++) begin
        if (a_red[k] > AngHalfPi) begin
          a_red[k] = a_red[k] - AngPi;
          f_red[k] = ~f_red[k];
        end else if (a_red[k] < -AngHalfPi) begin
          a_red[k] = a_red[k] + AngPi;
          f_red[k] = ~f_red[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int s = 1; s < NS; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q[0] <= pt_i;
      for (int k = 0; k < 3; k++) begin
        x_q[k][0] <= CordicGain;
        y_q[k][0] <= '0;
        a_q[k][0] <= a_red[k];
        flip_q[k][0] <= f_red[k];
      end
      for (int s = 1; s < NS; s++) begin
        pt_q[s] <= pt_q[s-1];
        for (int k = 0; k < 3; k++) begin
          flip_q[k][s] <= flip_q[k][s-1];
          if (!a_q[k][s-1][AngW-1]) begin
            x_q[k][s] <= x_q[k][s-1] - (y_q[k][s-1] >>> (s-1));
            y_q[k][s] <= y_q[k][s-1] + (x_q[k][s-1] >>> (s-1));
            a_q[k][s] <= a_q[k][s-1] - atan_q16(s-1);
          end else begin
            x_q[k][s] <= x_q[k][s-1] + (y_q[k][s-1] >>> (s-1));
            y_q[k][s] <= y_q[k][s-1] - (x_q[k][s-1] >>> (s-1));
            a_q[k][s] <= a_q[k][s-1] + atan_q16(s-1);
          end
        end
      end
    end
  end

  trig_t t_out [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_out[k].c = flip_q[k][NS-1] ? -x_q[k][NS-1] : x_q[k][NS-1];
      t_out[k].s = flip_q[k][NS-1] ? -y_q[k][NS-1] : y_q[k][NS-1];
    end
  end

  assign vld_o = vld_q[NS-1];
  assign pt_o = pt_q[NS-1];
  assign trig_o.roll = t_out[0];
  assign trig_o.pitch = t_out[1];
  assign trig_o.yaw = t_out[2];

endmodule

// ===== sv/fter_rotate.sv =====
// Pipelined yaw, pitch, roll and mount rotations with saturation.
module fter_rotate import fter_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  trig3_t                 trig_i,
  input  pt_t                    pt_i,
  output logic                   vld_o,
  output logic signed [OutW-1:0] ik_x_o,
  output logic signed [OutW-1:0] ik_y_o,
  output logic signed [OutW-1:0] ik_z_o
);

  localparam int unsigned PW = 40;

  // Stage bookkeeping: 0 yaw mult, 1 yaw sum, 2 pitch mult, 3 pitch sum,
  // 4 roll mult, 5 roll sum, 6 mount mult, 7 mount sum, 8 saturate.
  logic [8:0] vld_q;

  logic signed [PW-1:0] m0a_q, m0b_q, m0c_q, m0d_q;
  logic signed [16:0]   z0_q;
  trig_t                p0_q, r0_q, p1_q, r1_q, r2_q, r3_q;
  logic signed [15:0]   px_q [6];
  logic signed [15:0]   py_q [6];
  logic signed [15:0]   mc_q [6];
  logic signed [15:0]   ms_q [6];
  logic signed [PosW+1:0] x1_q, y1_q, y1b_q, y1c_q;
  logic signed [16:0]   z1_q;
  logic signed [PW-1:0] m2a_q, m2b_q, m2c_q, m2d_q;
  logic signed [PosW+1:0] x2_q, z2_q, x2b_q, x2c_q;
  logic signed [PW-1:0] m4a_q, m4b_q, m4c_q, m4d_q;
  logic signed [PosW+1:0] y3_q, z3_q, z3b_q, z3c_q;
  logic signed [PW-1:0] m6a_q, m6b_q, m6c_q, m6d_q;
  logic signed [47:0]   ox_q, oy_q;
  logic signed [OutW-1:0] ikx_q, iky_q, ikz_q;

  function automatic logic signed [PosW+1:0] rnd16(input logic signed [PW-1:0] a,
                                                   input logic signed [PW-1:0] b,
                                                   input logic sub);
    logic signed [PW:0] t;
    t = sub ? ({a[PW-1], a} - {b[PW-1], b}) : ({a[PW-1], a} + {b[PW-1], b});
    t = t + (PW+1)'(32768);
    return t[PosW+17:16];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[7:0], vld_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q[0] <= pt_i.pivot_x;
      py_q[0] <= pt_i.pivot_y;
      mc_q[0] <= pt_i.mount_cosine;
      ms_q[0] <= pt_i.mount_sine;
      for (int s = 1; s < 6; s++) begin
        px_q[s] <= px_q[s-1];
        py_q[s] <= py_q[s-1];
      end
      for (int s = 1; s < 6; s++) begin
        mc_q[s] <= mc_q[s-1];
        ms_q[s] <= ms_q[s-1];
      end
      // yaw
      m0a_q <= PW'(pt_i.x * trig_i.yaw.c);
      m0b_q <= PW'(pt_i.y * trig_i.yaw.s);
      m0c_q <= PW'(pt_i.x * trig_i.yaw.s);
      m0d_q <= PW'(pt_i.y * trig_i.yaw.c);
      z0_q <= pt_i.z;
      p0_q <= trig_i.pitch;
      r0_q <= trig_i.roll;
      x1_q <= rnd16(m0a_q, m0b_q, 1'b1);
      y1_q <= rnd16(m0c_q, m0d_q, 1'b0);
      z1_q <= z0_q;
      p1_q <= p0_q;
      r1_q <= r0_q;
      // pitch
      m2a_q <= PW'(x1_q * p1_q.c);
      m2b_q <= PW'(z1_q * p1_q.s);
      m2c_q <= PW'(z1_q * p1_q.c);
      m2d_q <= PW'(x1_q * p1_q.s);
      y1b_q <= y1_q;
      r2_q <= r1_q;
      x2_q <= rnd16(m2a_q, m2b_q, 1'b0);
      z2_q <= rnd16(m2c_q, m2d_q, 1'b1);
      y1c_q <= y1b_q;
      r3_q <= r2_q;
      // roll
      m4a_q <= PW'(y1c_q * r3_q.c);
      m4b_q <= PW'(z2_q * r3_q.s);
      m4c_q <= PW'(y1c_q * r3_q.s);
      m4d_q <= PW'(z2_q * r3_q.c);
      x2b_q <= x2_q;
      y3_q <= rnd16(m4a_q, m4b_q, 1'b1);
      z3_q <= rnd16(m4c_q, m4d_q, 1'b0);
      x2c_q <= x2b_q;
      // mount: relative x/y then Q1.14 rotation
      m6a_q <= PW'((x2c_q - px_q[5]) * mc_q[5]);
      m6b_q <= PW'((y3_q - py_q[5]) * ms_q[5]);
      m6c_q <= PW'((y3_q - py_q[5]) * mc_q[5]);
      m6d_q <= PW'((x2c_q - px_q[5]) * ms_q[5]);
      z3b_q <= z3_q;
      ox_q <= (48'(m6a_q) + 48'(m6b_q) + 48'sd8192) >>> 14;
      oy_q <= (48'(m6c_q) - 48'(m6d_q) + 48'sd8192) >>> 14;
      z3c_q <= z3b_q;
      ikx_q <= sat18(ox_q);
      iky_q <= sat18(oy_q);
      ikz_q <= sat18(48'(z3c_q));
    end
  end

  assign vld_o = vld_q[8];
  assign ik_x_o = ikx_q;
  assign ik_y_o = iky_q;
  assign ik_z_o = ikz_q;

endmodule

// ===== sv/foot_target_euler_rotate_unit.sv =====
// Top level of the foot target rotation unit.
// Maps one leg's foot target into the leg-local inverse-kinematics frame.
// Input channel s_axis: one request per leg carrying foot target, pivot,
// mount cosine/sine, body height and roll/pitch/yaw angles in tdata.
// Output channel m_axis: ik_x, ik_y, ik_z, each 18-bit saturated, in tdata.
// Throughput: one request per cycle while the receiver does not stall. Path from
// acceptance to result: one entry register, 17 CORDIC stages (a 16-step CORDIC
// run per angle) and 9 rotation stages, the last of which drives m_axis.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, the pipeline holds and s_axis_tready drops, nothing lost.
// Reset clears all valid bits; payload registers are not reset.
module foot_target_euler_rotate_unit import fter_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: foot_x, foot_y, foot_z, pivot_x, pivot_y, mount_cosine,
  // mount_sine, body_height[14:0], roll_angle, pitch_angle, yaw_angle, pad
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: ik_x, ik_y, ik_z, pad
  output logic [55:0]  m_axis_tdata
);

  req_t   req_q;
  logic   in_vld_q;
  logic   en;
  logic   cv;
  trig3_t trig;
  pt_t    pt_in, pt_out;
  logic   rv;
  logic signed [OutW-1:0] ikx, iky, ikz;

  // Advance when the output slot is free or being taken.
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (en) in_vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      req_q.foot_x <= s_axis_tdata[15:0];
      req_q.foot_y <= s_axis_tdata[31:16];
      req_q.foot_z <= s_axis_tdata[47:32];
      req_q.pivot_x <= s_axis_tdata[63:48];
      req_q.pivot_y <= s_axis_tdata[79:64];
      req_q.mount_cosine <= s_axis_tdata[95:80];
      req_q.mount_sine <= s_axis_tdata[111:96];
      req_q.body_height <= s_axis_tdata[126:112];
      req_q.roll_angle <= s_axis_tdata[142:127];
      req_q.pitch_angle <= s_axis_tdata[158:143];
      req_q.yaw_angle <= s_axis_tdata[174:159];
    end
  end

  assign pt_in.x = 17'(req_q.pivot_x) + 17'(req_q.foot_x);
  assign pt_in.y = 17'(req_q.pivot_y) + 17'(req_q.foot_y);
  assign pt_in.z = 17'(req_q.foot_z) - $signed({2'b00, req_q.body_height});
  assign pt_in.pivot_x = req_q.pivot_x;
  assign pt_in.pivot_y = req_q.pivot_y;
  assign pt_in.mount_cosine = req_q.mount_cosine;
  assign pt_in.mount_sine = req_q.mount_sine;

  fter_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_vld_q),
    .roll_i  (req_q.roll_angle),
    .pitch_i (req_q.pitch_angle),
    .yaw_i   (req_q.yaw_angle),
    .pt_i    (pt_in),
    .vld_o   (cv),
    .trig_o  (trig),
    .pt_o    (pt_out)
  );

  fter_rotate u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (cv),
    .trig_i (trig),
    .pt_i   (pt_out),
    .vld_o  (rv),
    .ik_x_o (ikx),
    .ik_y_o (iky),
    .ik_z_o (ikz)
  );

  assign m_axis_tvalid = rv;
  assign m_axis_tdata = {2'b00, ikz, iky, ikx};

endmodule

// ===== sv/fter_checker.sv =====
// Port-level checker for the foot target rotation unit, bound to the top.
`include "foot_target_euler_rotate_unit_assert.svh"
module fter_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [55:0]  m_axis_tdata
);
  // A stalled result holds.
  `FTER_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  // Input is taken whenever the output is free.
  `FTER_ASSERT_IMP(a_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  // Padding stays zero.
  `FTER_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[55:54] == 2'b00)
  // A stalled output blocks input.
  `FTER_ASSERT_IMP(a_block, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind foot_target_euler_rotate_unit fter_checker u_fter_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_top.sv =====
// Testbench for the foot target rotation unit: random legs against a built-in predictor.
`timescale 1ns / 1ps

class ik_scoreboard;
  logic [17:0] pend_x[$];
  logic [17:0] pend_y[$];
  logic [17:0] pend_z[$];
  int errors = 0;

  static function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  static function logic [17:0] clip18(longint v);
    if (v > 131071) return 18'h1ffff;
    if (v < -131072) return 18'h20000;
    return v[17:0];
  endfunction

  static function void trig(logic signed [15:0] ang, output longint c, output longint s);
    longint a, x, y, nx, ny;
    bit flip;
    longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
    a = longint'(ang) * 16;
    flip = 0;
    x = 39797;
    y = 0;
    for (int i = 0; i < 4; i++) begin
      if (a > 102944) begin
        a -= 205887; flip = !flip;
      end else if (a < -102944) begin
        a += 205887; flip = !flip;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (a >= 0) begin
        nx = x - asr(y, i); ny = y + asr(x, i); a -= atan_tab[i];
      end else begin
        nx = x + asr(y, i); ny = y - asr(x, i); a += atan_tab[i];
      end
      x = nx; y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Predict the leg-local target of one accepted request.
  function void note_request(logic [175:0] d);
    longint fx, fy, fz, px, py, mc, ms, h, cr, sr, cp, sp, cy, sy;
    longint x, y, z, x1, y1, z1, y2, z2, ox, oy;
    fx = longint'($signed(d[15:0]));
    fy = longint'($signed(d[31:16]));
    fz = longint'($signed(d[47:32]));
    px = longint'($signed(d[63:48]));
    py = longint'($signed(d[79:64]));
    mc = longint'($signed(d[95:80]));
    ms = longint'($signed(d[111:96]));
    h = longint'(d[126:112]);
    trig(d[142:127], cr, sr);
    trig(d[158:143], cp, sp);
    trig(d[174:159], cy, sy);
    x = px + fx; y = py + fy; z = fz - h;
    x1 = rnd(x * cy - y * sy, 16);
    y1 = rnd(x * sy + y * cy, 16);
    x = rnd(x1 * cp + z * sp, 16);
    z1 = rnd(z * cp - x1 * sp, 16);
    y2 = rnd(y1 * cr - z1 * sr, 16);
    z2 = rnd(y1 * sr + z1 * cr, 16);
    x = x - px;
    y = y2 - py;
    ox = rnd(x * mc + y * ms, 14);
    oy = rnd(y * mc - x * ms, 14);
    pend_x.push_back(clip18(ox));
    pend_y.push_back(clip18(oy));
    pend_z.push_back(clip18(z2));
  endfunction

  function void check_result(logic [55:0] d);
    logic [17:0] ex, ey, ez;
    if (pend_x.size() == 0) begin
      $error("unexpected result %h", d);
      errors++;
      return;
    end
    ex = pend_x.pop_front();
    ey = pend_y.pop_front();
    ez = pend_z.pop_front();
    if (d[17:0] !== ex) begin
      $error("ik_x expected %0d actual %0d", $signed(ex), $signed(d[17:0])); errors++;
    end
    if (d[35:18] !== ey) begin
      $error("ik_y expected %0d actual %0d", $signed(ey), $signed(d[35:18])); errors++;
    end
    if (d[53:36] !== ez) begin
      $error("ik_z expected %0d actual %0d", $signed(ez), $signed(d[53:36])); errors++;
    end
  endfunction
endclass

module tb_top;
  import fter_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [55:0] m_axis_tdata;

  ik_scoreboard board = new();
  bit sending_done = 0;
  bit long_hold = 0;

  foot_target_euler_rotate_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Pack one leg request; fields go from the lowest bit up.
  function automatic logic [175:0] pack_leg(logic [15:0] fx, fy, fz, px, py, mc, ms,
                                            logic [14:0] h, logic [15:0] r, p, w);
    return {1'b0, w, p, r, h, ms, mc, py, px, fz, fy, fx};
  endfunction

  function automatic logic [15:0] rand_mount();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [175:0] rand_leg();
    logic [15:0] mc, ms;
    if ($urandom_range(3) == 0) begin
      mc = 16'($urandom); ms = 16'($urandom);
    end else begin
      mc = rand_mount(); ms = rand_mount();
    end
    if ($urandom_range(1))
      return pack_leg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), mc, ms, 15'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
    // realistic leg: modest positions and angles
    return pack_leg(16'($signed($urandom_range(8000)) - 4000),
                    16'($signed($urandom_range(8000)) - 4000),
                    16'($signed($urandom_range(4000)) - 2000),
                    16'($signed($urandom_range(4000)) - 2000),
                    16'($signed($urandom_range(4000)) - 2000), mc, ms,
                    15'($urandom_range(3000)),
                    16'($signed($urandom_range(3200)) - 1600),
                    16'($signed($urandom_range(3200)) - 1600),
                    16'($signed($urandom_range(26000)) - 13000));
  endfunction

  task automatic send_leg(logic [175:0] d);
    s_axis_tdata <= d;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(d);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);

  // Receiver: own stall pattern plus one long hold-off.
  initial begin
    int mode;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      mode = $urandom_range(3);
      repeat ($urandom_range(40, 5)) begin
        if (long_hold) m_axis_tready <= 0;
        else if (mode == 0) m_axis_tready <= 1;
        else m_axis_tready <= ($urandom_range(mode) == 0);
        @(negedge clk_i);
      end
    end
  end

  initial begin
    logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // extremes of positions, angles, height and mount terms
    for (int i = 0; i < 4; i++)
      send_leg(pack_leg(ext[i], ext[i], ext[i], ext[i], ext[i], ext[i], ext[i],
                        ext[i][14:0], ext[i], ext[i], ext[i]));
    send_leg(pack_leg(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'd16384,
                      16'd16384, 15'h7fff, 16'h7fff, 16'h8000, 16'h7fff));
    send_leg(pack_leg(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, -16'sd16384,
                      16'd16384, 15'd0, 16'h8000, 16'h7fff, 16'h8000));
    send_leg(pack_leg(16'd100, 16'd200, 16'd0, 16'd50, 16'd60, 16'd16384, 16'd0,
                      15'd800, 16'd6434, -16'sd6434, 16'd12868));
    send_leg(pack_leg(16'd100, 16'd200, 16'd0, 16'd50, 16'd60, 16'd0, -16'sd16384,
                      15'd800, 16'd6433, 16'd6435, -16'sd12869));
    send_leg(pack_leg(16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h7fff,
                      15'd0, 16'd25736, -16'sd25736, 16'd19302));
    // long hold-off so the pipeline fills and backs up
    fork
      begin
        long_hold = 1;
        repeat (120) @(negedge clk_i);
        long_hold = 0;
      end
      for (int i = 0; i < 60; i++) send_leg(rand_leg());
    join
    for (int n = 0; n < 890; ) begin
      int burst, gap;
      burst = $urandom_range(30, 1);
      for (int i = 0; i < burst; i++, n++) send_leg(rand_leg());
      gap = ($urandom_range(2) != 0) ? $urandom_range(6) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (board.pend_x.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
